// ===== src/dfrc_pkg.sv =====
// Shared types and constants for the dimmer fade ramp controller.
package dfrc_pkg;

    // Default level width, unsigned Q0.LEVEL_BITS
    localparam int LEVEL_BITS_DEF = 16;

    // Configuration register index width and indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_LEVEL = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_LEVEL = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RAMP_STEP = 2'd2;

    // Event kinds
    typedef enum logic [1:0] {
        OP_SWITCH = 2'd0,
        OP_TARGET = 2'd1,
        OP_TICK   = 2'd2,
        OP_ANALOG = 2'd3
    } t_op;

    // Light status codes
    typedef enum logic [2:0] {
        ST_OFF         = 3'd0,
        ST_ON          = 3'd1,
        ST_MID         = 3'd2,
        ST_TO_FULL_ON  = 3'd3,
        ST_TO_FULL_OFF = 3'd4,
        ST_RISING      = 3'd5,
        ST_FALLING     = 3'd6
    } t_status;

    // Lamp command flags produced by one event
    typedef struct packed {
        logic drive_valid;
        logic switch_valid;
        logic switch_cmd;
    } t_flags;

endpackage

// ===== src/dfrc_fade_core.sv =====
// Next-state and result logic for one dimmer event.
module dfrc_fade_core #(
    parameter int LEVEL_BITS = dfrc_pkg::LEVEL_BITS_DEF
) (
    input  dfrc_pkg::t_op         i_op,
    input  logic                  i_switch_on,
    input  logic [LEVEL_BITS-1:0] i_level_in,
    input  logic [LEVEL_BITS-1:0] i_min_level,
    input  logic [LEVEL_BITS-1:0] i_max_level,
    input  logic [LEVEL_BITS-1:0] i_ramp_step,
    input  logic [LEVEL_BITS-1:0] i_level_now,
    input  logic [LEVEL_BITS-1:0] i_fade_target,
    input  dfrc_pkg::t_status     i_status,
    output logic [LEVEL_BITS-1:0] o_level_next,
    output logic [LEVEL_BITS-1:0] o_target_next,
    output dfrc_pkg::t_status     o_status_next,
    output logic [LEVEL_BITS-1:0] o_drive_level,
    output dfrc_pkg::t_flags      o_flags
);

    localparam logic [LEVEL_BITS-1:0] LEVEL_FULL = {LEVEL_BITS{1'b1}};
    localparam logic [LEVEL_BITS-1:0] LEVEL_ZERO = '0;

    // Status shown while a fade toward tgt is under way
    function automatic dfrc_pkg::t_status fade_status(
        input logic [LEVEL_BITS-1:0] tgt,
        input logic [LEVEL_BITS-1:0] mx,
        input logic [LEVEL_BITS-1:0] mn,
        input logic [LEVEL_BITS-1:0] cur
    );
        dfrc_pkg::t_status st;
        if (tgt >= mx) begin
            st = dfrc_pkg::ST_TO_FULL_ON;
        end else if (tgt <= mn) begin
            st = dfrc_pkg::ST_TO_FULL_OFF;
        end else if (tgt >= cur) begin
            st = dfrc_pkg::ST_RISING;
        end else begin
            st = dfrc_pkg::ST_FALLING;
        end
        return st;
    endfunction

    logic                  fade_on;
    logic [LEVEL_BITS-1:0] clamp_hi;
    logic [LEVEL_BITS-1:0] clamped;
    logic [LEVEL_BITS:0]   sum_up;
    logic [LEVEL_BITS:0]   sum_dn;

    assign fade_on  = (i_ramp_step != LEVEL_ZERO);
    // max limit first, then min, so min wins on crossed limits
    assign clamp_hi = (i_level_in > i_max_level) ? i_max_level : i_level_in;
    assign clamped  = (clamp_hi < i_min_level) ? i_min_level : clamp_hi;
    assign sum_up   = {1'b0, i_level_now} + {1'b0, i_ramp_step};
    assign sum_dn   = {1'b0, i_fade_target} + {1'b0, i_ramp_step};

    // Event decode
    always_comb begin
        o_level_next  = i_level_now;
        o_target_next = i_fade_target;
        o_status_next = i_status;
        o_drive_level = LEVEL_ZERO;
        o_flags       = '0;
        case (i_op)
            dfrc_pkg::OP_SWITCH: begin
                o_flags.switch_valid = 1'b1;
                o_flags.switch_cmd   = i_switch_on;
                if (fade_on) begin
                    o_target_next = i_switch_on ? i_max_level : i_min_level;
                    o_status_next = fade_status(o_target_next, i_max_level,
                                                i_min_level, i_level_now);
                end else if (i_switch_on) begin
                    if (i_max_level != LEVEL_FULL) begin
                        o_flags.drive_valid = 1'b1;
                        o_drive_level       = i_max_level;
                    end
                    o_level_next  = i_max_level;
                    o_status_next = dfrc_pkg::ST_ON;
                end else begin
                    if (i_min_level != LEVEL_ZERO) begin
                        o_flags.drive_valid = 1'b1;
                        o_drive_level       = i_min_level;
                    end
                    o_level_next  = i_min_level;
                    o_status_next = dfrc_pkg::ST_OFF;
                end
            end
            dfrc_pkg::OP_TARGET: begin
                if (fade_on) begin
                    o_target_next = clamped;
                    o_status_next = fade_status(clamped, i_max_level,
                                                i_min_level, i_level_now);
                end else begin
                    o_flags.drive_valid = 1'b1;
                    o_drive_level       = clamped;
                    o_level_next        = clamped;
                    if (clamped >= i_max_level) begin
                        // behaves as an immediate switch-on
                        o_flags.switch_valid = 1'b1;
                        o_flags.switch_cmd   = 1'b1;
                        if (i_max_level != LEVEL_FULL) begin
                            o_drive_level = i_max_level;
                        end
                        o_level_next  = i_max_level;
                        o_status_next = dfrc_pkg::ST_ON;
                    end else if (clamped <= i_min_level) begin
                        // behaves as an immediate switch-off
                        o_flags.switch_valid = 1'b1;
                        o_flags.switch_cmd   = 1'b0;
                        if (i_min_level != LEVEL_ZERO) begin
                            o_drive_level = i_min_level;
                        end
                        o_level_next  = i_min_level;
                        o_status_next = dfrc_pkg::ST_OFF;
                    end else begin
                        o_status_next = dfrc_pkg::ST_MID;
                    end
                end
            end
            dfrc_pkg::OP_TICK: begin
                if (fade_on && (i_level_now != i_fade_target)) begin
                    if (i_fade_target > i_level_now) begin
                        if (sum_up >= {1'b0, i_fade_target}) begin
                            o_level_next  = i_fade_target;
                            o_status_next = (i_fade_target >= i_max_level) ?
                                            dfrc_pkg::ST_ON : dfrc_pkg::ST_MID;
                        end else begin
                            o_level_next = sum_up[LEVEL_BITS-1:0];
                        end
                    end else begin
                        if ({1'b0, i_level_now} <= sum_dn) begin
                            o_level_next  = i_fade_target;
                            o_status_next = (i_fade_target <= i_min_level) ?
                                            dfrc_pkg::ST_OFF : dfrc_pkg::ST_MID;
                        end else begin
                            o_level_next = i_level_now - i_ramp_step;
                        end
                    end
                    o_flags.drive_valid = 1'b1;
                    o_drive_level       = o_level_next;
                end
            end
            dfrc_pkg::OP_ANALOG: begin
                if (i_level_in >= i_max_level) begin
                    o_status_next = dfrc_pkg::ST_ON;
                    o_level_next  = i_max_level;
                end else if (i_level_in <= i_min_level) begin
                    o_status_next = dfrc_pkg::ST_OFF;
                    o_level_next  = i_min_level;
                end else begin
                    o_status_next = dfrc_pkg::ST_MID;
                    o_level_next  = i_level_in;
                end
                o_target_next        = o_level_next;
                o_flags.switch_valid = 1'b1;
                o_flags.switch_cmd   = (o_status_next != dfrc_pkg::ST_OFF);
                o_flags.drive_valid  = 1'b1;
                o_drive_level        = o_level_next;
            end
            default: begin
                o_level_next = i_level_now;
            end
        endcase
    end

endmodule

// ===== src/dimmer_fade_ramp_controller_top.sv =====
// Top level of the dimmer fade ramp controller: stream ports, state and config registers.
//
// Dimmable light controller. Each input word is one event (on/off, set target,
// minute tick, set analog); each event yields exactly one result word with the
// new level, the status and any lamp drive/switch commands. The block takes one
// event per clock cycle while the result is not stalled. An accepted event is held
// in the input register and moves into the result register when the result slot
// is free; a stalled result holds the input register and drops s_axis_tready. The
// rate is set by the level/target/status registers: an event's decode, clamp and
// one add/compare close back into them. Configuration (min level, max level, ramp
// step) is to be written by the user through its own channel while the stream is
// idle; the block itself does not enforce this. Writes to an index outside the
// three registers are accepted and dropped.
module dimmer_fade_ramp_controller_top #(
    parameter int LEVEL_BITS = dfrc_pkg::LEVEL_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dfrc_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [LEVEL_BITS-1:0]             i_cfg_data,
    // event input
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata, low bit up: switch_on, level_in, zero fill
    input  logic [((LEVEL_BITS+8)/8)*8-1:0]   s_axis_tdata,
    // tuser: op
    input  logic [1:0]                        s_axis_tuser,
    // result output
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata, low bit up: current_level, light_status, drive_valid,
    // drive_level, switch_valid, switch_cmd, zero fill
    output logic [((2*LEVEL_BITS+13)/8)*8-1:0] m_axis_tdata
);

    localparam int OUT_W = ((2*LEVEL_BITS+13)/8)*8;

    // configuration
    logic [LEVEL_BITS-1:0] r_min_level;
    logic [LEVEL_BITS-1:0] r_max_level;
    logic [LEVEL_BITS-1:0] r_ramp_step;

    // light state
    logic [LEVEL_BITS-1:0] r_level;
    logic [LEVEL_BITS-1:0] r_target;
    dfrc_pkg::t_status     r_status;

    // input register
    logic                  r_in_valid;
    dfrc_pkg::t_op         r_in_op;
    logic                  r_in_switch_on;
    logic [LEVEL_BITS-1:0] r_in_level;

    // result register
    logic                  r_out_valid;
    logic [LEVEL_BITS-1:0] r_out_level;
    dfrc_pkg::t_status     r_out_status;
    logic [LEVEL_BITS-1:0] r_out_drive_level;
    dfrc_pkg::t_flags      r_out_flags;

    logic                  in_take;
    logic                  advance;
    logic [LEVEL_BITS-1:0] n_level;
    logic [LEVEL_BITS-1:0] n_target;
    dfrc_pkg::t_status     n_status;
    logic [LEVEL_BITS-1:0] n_drive_level;
    dfrc_pkg::t_flags      n_flags;

    // handshake: the input register moves on when the result slot is free
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_level <= '0;
            r_max_level <= {LEVEL_BITS{1'b1}};
            r_ramp_step <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dfrc_pkg::CFG_MIN_LEVEL: r_min_level <= i_cfg_data;
                dfrc_pkg::CFG_MAX_LEVEL: r_max_level <= i_cfg_data;
                dfrc_pkg::CFG_RAMP_STEP: r_ramp_step <= i_cfg_data;
                default: r_ramp_step <= r_ramp_step;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op        <= dfrc_pkg::t_op'(s_axis_tuser);
            r_in_switch_on <= s_axis_tdata[0];
            r_in_level     <= s_axis_tdata[LEVEL_BITS:1];
        end
    end

    // event logic
    dfrc_fade_core #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_core (
        .i_op          (r_in_op),
        .i_switch_on   (r_in_switch_on),
        .i_level_in    (r_in_level),
        .i_min_level   (r_min_level),
        .i_max_level   (r_max_level),
        .i_ramp_step   (r_ramp_step),
        .i_level_now   (r_level),
        .i_fade_target (r_target),
        .i_status      (r_status),
        .o_level_next  (n_level),
        .o_target_next (n_target),
        .o_status_next (n_status),
        .o_drive_level (n_drive_level),
        .o_flags       (n_flags)
    );

    // light state, updated as each event moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= '0;
            r_target <= '0;
            r_status <= dfrc_pkg::ST_OFF;
        end else if (advance) begin
            r_level  <= n_level;
            r_target <= n_target;
            r_status <= n_status;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_level       <= n_level;
            r_out_status      <= n_status;
            r_out_drive_level <= n_drive_level;
            r_out_flags       <= n_flags;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_out_flags.switch_cmd, r_out_flags.switch_valid,
                                   r_out_drive_level, r_out_flags.drive_valid,
                                   r_out_status, r_out_level});

    // checks
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_level) && $stable(r_target) && $stable(r_status))
        else $error("light state changed without an event");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("event did not reach the result register");

    a_level_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_level == r_level) && (r_out_status == r_status))
        else $error("pending result disagrees with light state");

    a_drive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_flags.drive_valid) |-> (r_out_drive_level == '0))
        else $error("drive level set without a drive command");

    a_off_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_flags.switch_valid && (r_out_status == dfrc_pkg::ST_OFF))
        |-> !r_out_flags.switch_cmd)
        else $error("switch-on command with status off");

endmodule
